// ===== sv/s256_pkg.sv =====
package s256_pkg;

  localparam int unsigned QueueDepth = 2;

  // Byte-side commands handed from the front part to the compression engine
  typedef enum logic [1:0] {
    CMD_BLOCK  = 2'd0,  // compress a full message block
    CMD_FINAL  = 2'd1,  // compress the last block and emit the digest
    CMD_FINAL2 = 2'd2,  // compress a padding block, then a length-only block, emit
    CMD_FINALP = 2'd3   // compress a full data block, then a pad-and-length block, emit
  } cmd_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [511:0] blk;
    logic [63:0]  bits;
  } job_t;

  localparam logic [255:0] InitH = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

endpackage

// ===== sv/s256_front.sv =====
// Collect bytes into a block register; hand full or closing blocks to the queue
module s256_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  logic [7:0]        in_data_byte,
  input  logic              in_has_byte,
  input  logic              in_last,
  output logic              job_valid,
  input  logic              job_ready,
  output s256_pkg::job_t    job
);

  logic [511:0] blk_r, blk_nxt;
  logic [5:0]   fill_r, fill_nxt;
  logic [60:0]  cnt_r, cnt_nxt;
  logic         acc;
  logic [6:0]   nfill;
  logic [60:0]  ncnt;
  logic [511:0] wblk, pblk;
  logic         close;
  logic [9:0]   sh;

  assign close = in_last;
  assign in_full = !job_ready;
  assign acc = in_push && !in_full;

  always_comb begin
    wblk  = blk_r;
    nfill = {1'b0, fill_r};
    ncnt  = cnt_r;
    sh    = 10'(9'd504 - {fill_r, 3'b000});
    if (in_has_byte) begin
      wblk  = (blk_r & ~(512'hff << sh)) | (512'(in_data_byte) << sh);
      nfill = 7'({1'b0, fill_r} + 7'd1);
      ncnt  = cnt_r + 61'd1;
    end
    // place the pad byte after the last data byte and clear the rest of the block
    pblk = wblk & ~(512'h0 - 512'h1 >> {nfill[5:0], 3'b000}) ;
    pblk = pblk | (nfill[6] ? 512'h0 : (512'h80 << 10'(9'd504 - {nfill[5:0], 3'b000})));
    if (nfill[6]) pblk = wblk;
  end

  always_comb begin
    job_valid = 1'b0;
    job.cmd   = s256_pkg::CMD_BLOCK;
    job.blk   = wblk;
    job.bits  = {ncnt, 3'b000};
    blk_nxt   = blk_r;
    fill_nxt  = fill_r;
    cnt_nxt   = cnt_r;
    if (acc) begin
      blk_nxt  = wblk;
      fill_nxt = nfill[5:0];
      cnt_nxt  = ncnt;
      if (close) begin
        job_valid = 1'b1;
        fill_nxt  = '0;
        cnt_nxt   = '0;
        if (nfill[6]) begin
          // block is all data; the pad byte goes into the length block
          job.cmd = s256_pkg::CMD_FINALP;
          job.blk = wblk;
        end else if (nfill > 7'd55) begin
          job.cmd = s256_pkg::CMD_FINAL2;
          job.blk = pblk;
        end else begin
          job.cmd = s256_pkg::CMD_FINAL;
          job.blk = {pblk[511:64], ncnt, 3'b000};
        end
      end else if (nfill[6]) begin
        job_valid = 1'b1;
        job.cmd   = s256_pkg::CMD_BLOCK;
      end
    end
  end

  always_ff @(posedge clk) begin
    blk_r <= blk_nxt;
    if (!rst_n) begin
      fill_r <= '0;
      cnt_r  <= '0;
    end else begin
      fill_r <= fill_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

// ===== sv/s256_queue.sv =====
// Short job queue between the byte collector and the compression engine
module s256_queue #(
  parameter int unsigned DEPTH = s256_pkg::QueueDepth
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  s256_pkg::job_t wr_job,
  output logic           rd_valid,
  input  logic           rd_ready,
  output s256_pkg::job_t rd_job
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  s256_pkg::job_t      mem_r [DEPTH];
  logic [AW-1:0]       wp_r, rp_r;
  logic [AW:0]         cnt_r;
  logic                wr, rd;

  assign wr_ready = cnt_r != (AW+1)'(DEPTH);
  assign rd_valid = cnt_r != '0;
  assign rd_job   = mem_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_job;
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : AW'(wp_r + 1'b1);
      if (rd) rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : AW'(rp_r + 1'b1);
      cnt_r <= (AW+1)'(cnt_r + (AW+1)'(wr) - (AW+1)'(rd));
    end
  end

endmodule

// ===== sv/s256_core.sv =====
// One SHA-256 round per cycle, message schedule as a 16-word window
module s256_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           job_valid,
  output logic           job_ready,
  input  s256_pkg::job_t job,
  output logic           out_empty,
  input  logic           out_pop,
  output logic [63:0]    out_digest_word,
  output logic [1:0]     out_word_index,
  output logic           out_last_word
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RUN  = 4'b0010,
    ST_ADD  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  state_t        st_r, st_nxt;
  logic [255:0]  h_r, h_nxt;
  logic [255:0]  v_r, v_nxt;
  logic [511:0]  w_r, w_nxt;
  logic [5:0]    rnd_r, rnd_nxt;
  logic          fin_r, fin_nxt;
  logic          more_r, more_nxt;
  logic          pad_r, pad_nxt;
  logic [63:0]   bits_r, bits_nxt;
  logic [1:0]    idx_r, idx_nxt;
  logic [31:0]   a, b, c, d, e, f, g, hh, w0, t1, t2, s0, s1, wn;
  logic [255:0]  hsum;

  function automatic logic [31:0] rr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  always_comb begin
    {a, b, c, d, e, f, g, hh} = v_r;
    w0 = w_r[511:480];
    t1 = hh + (rr(e, 6) ^ rr(e, 11) ^ rr(e, 25)) + ((e & f) ^ (~e & g))
       + s256_pkg::round_k(rnd_r) + w0;
    t2 = (rr(a, 2) ^ rr(a, 13) ^ rr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
    s0 = rr(w_r[479:448], 7) ^ rr(w_r[479:448], 18) ^ (w_r[479:448] >> 3);
    s1 = rr(w_r[63:32], 17) ^ rr(w_r[63:32], 19) ^ (w_r[63:32] >> 10);
    wn = w0 + s0 + w_r[223:192] + s1;
    for (int i = 0; i < 8; i++) hsum[i*32 +: 32] = h_r[i*32 +: 32] + v_r[i*32 +: 32];
  end

  assign job_ready       = st_r == ST_IDLE;
  assign out_empty       = st_r != ST_OUT;
  assign out_digest_word = h_r[255 - 64*idx_r -: 64];
  assign out_word_index  = idx_r;
  assign out_last_word   = idx_r == 2'd3;

  always_comb begin
    st_nxt = st_r; h_nxt = h_r; v_nxt = v_r; w_nxt = w_r; rnd_nxt = rnd_r;
    fin_nxt = fin_r; more_nxt = more_r; pad_nxt = pad_r; bits_nxt = bits_r;
    idx_nxt = idx_r;
    case (st_r)
      ST_IDLE: if (job_valid) begin
        w_nxt    = job.blk;
        v_nxt    = h_r;
        rnd_nxt  = '0;
        bits_nxt = job.bits;
        fin_nxt  = job.cmd != s256_pkg::CMD_BLOCK;
        more_nxt = (job.cmd == s256_pkg::CMD_FINAL2) || (job.cmd == s256_pkg::CMD_FINALP);
        pad_nxt  = job.cmd == s256_pkg::CMD_FINALP;
        st_nxt   = ST_RUN;
      end
      ST_RUN: begin
        v_nxt   = {t1 + t2, a, b, c, d + t1, e, f, g};
        w_nxt   = {w_r[479:0], wn};
        rnd_nxt = 6'(rnd_r + 6'd1);
        if (rnd_r == 6'd63) st_nxt = ST_ADD;
      end
      ST_ADD: begin
        h_nxt = hsum;
        if (more_r) begin
          // second closing block: pad byte only when the first was all data, then the length
          v_nxt    = hsum;
          w_nxt    = {(pad_r ? 8'h80 : 8'h00), 440'h0, bits_r};
          more_nxt = 1'b0;
          pad_nxt  = 1'b0;
          st_nxt   = ST_RUN;
        end else if (fin_r) begin
          idx_nxt = '0;
          st_nxt  = ST_OUT;
        end else begin
          st_nxt = ST_IDLE;
        end
      end
      ST_OUT: if (out_pop) begin
        idx_nxt = 2'(idx_r + 2'd1);
        if (idx_r == 2'd3) begin
          h_nxt  = s256_pkg::InitH;
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    v_r <= v_nxt; w_r <= w_nxt; bits_r <= bits_nxt;
    if (!rst_n) begin
      st_r <= ST_IDLE; h_r <= s256_pkg::InitH; rnd_r <= '0;
      fin_r <= 1'b0; more_r <= 1'b0; pad_r <= 1'b0; idx_r <= '0;
    end else begin
      st_r <= st_nxt; h_r <= h_nxt; rnd_r <= rnd_nxt;
      fin_r <= fin_nxt; more_r <= more_nxt; pad_r <= pad_nxt; idx_r <= idx_nxt;
    end
  end

endmodule

// ===== sv/sha256_stream_hasher_unit.sv =====
// SHA-256 stream hasher. Push one byte per transaction (in_has_byte low for a
// closing transaction with no byte); in_last ends the message and four 64-bit
// digest words follow, most significant first. Bytes are taken one per cycle
// while the job queue (two entries by default) has room. Each block passes
// the single-round compression engine as accept, 64 rounds and add, and a
// closing message whose padding does not fit needs a second block; the queue
// lets the next block gather while one is compressed.
module sha256_stream_hasher_unit #(
  parameter int unsigned QUEUE_DEPTH = s256_pkg::QueueDepth
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_has_byte,
  input  logic        in_last,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [63:0] out_digest_word,
  output logic [1:0]  out_word_index,
  output logic        out_last_word
);

  logic           fj_valid, fj_ready, cj_valid, cj_ready;
  s256_pkg::job_t fj, cj;

  s256_front u_front (
    .clk, .rst_n, .in_push, .in_full, .in_data_byte, .in_has_byte, .in_last,
    .job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
  );

  s256_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst_n, .wr_valid(fj_valid), .wr_ready(fj_ready), .wr_job(fj),
    .rd_valid(cj_valid), .rd_ready(cj_ready), .rd_job(cj)
  );

  s256_core u_core (
    .clk, .rst_n, .job_valid(cj_valid), .job_ready(cj_ready), .job(cj),
    .out_empty, .out_pop, .out_digest_word, .out_word_index, .out_last_word
  );

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;

  logic        clk;
  logic        rst_n;
  logic        in_push;
  logic        in_full;
  logic [7:0]  in_data_byte;
  logic        in_has_byte;
  logic        in_last;
  logic        out_empty;
  logic        out_pop;
  logic [63:0] out_digest_word;
  logic [1:0]  out_word_index;
  logic        out_last_word;

  sha256_stream_hasher_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full),
    .in_data_byte(in_data_byte), .in_has_byte(in_has_byte), .in_last(in_last),
    .out_empty(out_empty), .out_pop(out_pop),
    .out_digest_word(out_digest_word), .out_word_index(out_word_index),
    .out_last_word(out_last_word)
  );

  typedef struct {
    logic [63:0] word;
    logic [1:0]  idx;
    logic        fin;
  } digest_word_t;

  typedef struct {
    logic [7:0]   data;
    logic         has;
    logic         lst;
    logic         known;
    logic [63:0]  w0;
  } stim_row_t;

  localparam logic [31:0] H0 [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };
  localparam logic [31:0] RK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  logic [31:0]  chain [8];
  logic [7:0]   blk_bytes [64];
  int unsigned  fill;
  logic [60:0]  msg_len;

  digest_word_t pending_digest_q [$];
  logic [63:0]  known_first_q [$];

  int  errors;
  int  items_sent;
  int  digests_seen;
  int  cycle_cnt;
  bit  idle_off;

  function automatic logic [31:0] ror(logic [31:0] v, int n);
    return (v >> n) | (v << (32 - n));
  endfunction

  task automatic compress_block();
    logic [31:0] w [64];
    logic [31:0] a [8];
    logic [31:0] t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = w[i-16] + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-7]
             + (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
    for (int i = 0; i < 8; i++) a[i] = chain[i];
    for (int i = 0; i < 64; i++) begin
      t1 = a[7] + (ror(a[4], 6) ^ ror(a[4], 11) ^ ror(a[4], 25))
           + ((a[4] & a[5]) ^ (~a[4] & a[6])) + RK[i] + w[i];
      t2 = (ror(a[0], 2) ^ ror(a[0], 13) ^ ror(a[0], 22))
           + ((a[0] & a[1]) ^ (a[0] & a[2]) ^ (a[1] & a[2]));
      a[7] = a[6]; a[6] = a[5]; a[5] = a[4]; a[4] = a[3] + t1;
      a[3] = a[2]; a[2] = a[1]; a[1] = a[0]; a[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] += a[i];
  endtask

  task automatic restart_message();
    for (int i = 0; i < 8; i++) chain[i] = H0[i];
    fill = 0;
    msg_len = '0;
  endtask

  task automatic add_byte(logic [7:0] b);
    blk_bytes[fill] = b;
    fill++;
    if (fill == 64) begin
      compress_block();
      fill = 0;
    end
  endtask

  // Advance the hash state by one accepted transaction and queue any digest words
  task automatic hash_item(logic [7:0] b, logic has, logic lst);
    logic [63:0] bit_len;
    digest_word_t d;
    if (has) begin
      msg_len++;
      add_byte(b);
    end
    if (lst) begin
      bit_len = {msg_len, 3'b000};
      blk_bytes[fill] = 8'h80;
      fill++;
      if (fill > 56) begin
        for (int i = fill; i < 64; i++) blk_bytes[i] = 8'h00;
        compress_block();
        fill = 0;
      end
      for (int i = fill; i < 56; i++) blk_bytes[i] = 8'h00;
      for (int i = 0; i < 8; i++) blk_bytes[56+i] = bit_len[63-8*i -: 8];
      compress_block();
      for (int k = 0; k < 4; k++) begin
        d.word = {chain[2*k], chain[2*k+1]};
        d.idx  = k[1:0];
        d.fin  = (k == 3);
        pending_digest_q.push_back(d);
      end
      restart_message();
    end
  endtask

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 2000000) begin
      $display("%0t: timeout, %0d digest words outstanding", $time, pending_digest_q.size());
      $display("sha256_stream_hasher_unit test failed");
      $finish;
    end
  end

  // Check each popped transaction against the oldest predicted word
  always @(posedge clk) begin
    digest_word_t e;
    if (rst_n && out_pop && !out_empty) begin
      if (pending_digest_q.size() == 0) begin
        $display("%0t: unexpected digest word %h", $time, out_digest_word);
        errors++;
      end else begin
        e = pending_digest_q.pop_front();
        if (e.idx == 2'd0 && known_first_q.size() > 0) begin
          if (known_first_q[0] !== e.word) begin
            $display("%0t: predictor first word: expected %h actual %h",
                     $time, known_first_q[0], e.word);
            errors++;
          end
          void'(known_first_q.pop_front());
        end
        if (out_digest_word !== e.word) begin
          $display("%0t: digest_word expected %h actual %h", $time, e.word, out_digest_word);
          errors++;
        end
        if (out_word_index !== e.idx) begin
          $display("%0t: word_index expected %0d actual %0d", $time, e.idx, out_word_index);
          errors++;
        end
        if (out_last_word !== e.fin) begin
          $display("%0t: last_word expected %0b actual %0b", $time, e.fin, out_last_word);
          errors++;
        end
        digests_seen++;
      end
    end
  end

  // Receiver stalls in random bursts
  initial begin
    int n;
    out_pop = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (!idle_off && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 17);
        out_pop <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        out_pop <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_item(logic [7:0] b, logic has, logic lst);
    int n;
    if (!idle_off && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 17);
      in_push <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_push      <= 1'b1;
    in_data_byte <= b;
    in_has_byte  <= has;
    in_last      <= lst;
    @(posedge clk);
    while (in_full) @(posedge clk);
    hash_item(b, has, lst);
    items_sent++;
  endtask

  stim_row_t stim_rows [$];

  task automatic add_row(logic [7:0] b, logic has, logic lst, logic known, logic [63:0] w0);
    stim_row_t r;
    r.data = b; r.has = has; r.lst = lst; r.known = known; r.w0 = w0;
    stim_rows.push_back(r);
  endtask

  initial begin
    int len;
    int mode;
    logic [7:0] b;
    rst_n        = 1'b0;
    in_push      = 1'b0;
    in_data_byte = '0;
    in_has_byte  = 1'b0;
    in_last      = 1'b0;
    errors       = 0;
    items_sent   = 0;
    digests_seen = 0;
    cycle_cnt    = 0;
    idle_off     = 1'b0;
    restart_message();
    for (int i = 0; i < 64; i++) blk_bytes[i] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty message, "abc", ignored empty items, full-range byte values
    add_row(8'h00, 1'b0, 1'b1, 1'b1, 64'he3b0c44298fc1c14);
    add_row(8'h61, 1'b1, 1'b0, 1'b0, '0);
    add_row(8'hff, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'h62, 1'b1, 1'b0, 1'b0, '0);
    add_row(8'h63, 1'b1, 1'b1, 1'b1, 64'hba7816bf8f01cfea);
    add_row(8'h00, 1'b1, 1'b0, 1'b0, '0);
    add_row(8'hff, 1'b1, 1'b0, 1'b0, '0);
    add_row(8'h55, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'haa, 1'b1, 1'b1, 1'b0, '0);
    add_row(8'hff, 1'b1, 1'b1, 1'b0, '0);
    add_row(8'h00, 1'b1, 1'b1, 1'b0, '0);
    add_row(8'h5a, 1'b0, 1'b1, 1'b0, '0);
    foreach (stim_rows[i]) begin
      if (stim_rows[i].known) known_first_q.push_back(stim_rows[i].w0);
      send_item(stim_rows[i].data, stim_rows[i].has, stim_rows[i].lst);
    end

    // Padding boundaries: lengths around 55, 56 and 64 bytes
    for (int j = 0; j < 4; j++) begin
      len = (j == 0) ? 55 : (j == 1) ? 56 : (j == 2) ? 63 : 64;
      for (int i = 0; i < len; i++)
        send_item(8'($urandom_range(0, 255)), 1'b1, (i == len - 1) && (j != 3));
      if (j == 3) send_item(8'h00, 1'b0, 1'b1);
    end

    // Random messages, mostly short, with stray empty items and an occasional block crossing
    while (items_sent < 380) begin
      if (items_sent > 320) idle_off = 1'b1;
      mode = $urandom_range(0, 9);
      len  = (mode == 0) ? $urandom_range(50, 70) : $urandom_range(0, 12);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 9) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        b = 8'($urandom_range(0, 255));
        send_item(b, 1'b1, 1'b0);
      end
      if ($urandom_range(0, 1)) send_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
      else send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    end
    in_push <= 1'b0;

    while (pending_digest_q.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("Hashed %0d input transactions, checked %0d digest words,", items_sent,
             digests_seen);
    $display("including empty, abc, padding-boundary and multi-block messages.");
    if (errors == 0 && pending_digest_q.size() == 0)
      $display("sha256_stream_hasher_unit test passed");
    else
      $display("sha256_stream_hasher_unit test failed");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/s256_pkg.sv
sv/s256_front.sv
sv/s256_queue.sv
sv/s256_core.sv
sv/sha256_stream_hasher_unit.sv
test/tb.sv
